// ===== src/speck64_128_block_cipher_assert.svh =====
// Assertion macros for the cipher block.
// Each one is clocked on aclk and is held off while aresetn is low.
`ifndef SPECK64_128_BLOCK_CIPHER_ASSERT_SVH
`define SPECK64_128_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge
`define SPK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent
`define SPK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SPK_ASSERT(lbl, prop)
`define SPK_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/spk_pkg.sv =====
package spk_pkg;

    // Word size and rotation amounts of the 64/128 variant
    localparam int WORD_W    = 32;
    localparam int ROT_A     = 8;
    localparam int ROT_B     = 3;

    // Key registers on the write port
    localparam int KEY_WORDS = 4;
    localparam int CFG_IDX_W = 3;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } opcode_t;

endpackage

// ===== src/spk_round.sv =====
// One ARX round, forward or inverse. Shared by key expansion and the cipher.
module spk_round (
    input  spk_pkg::word_t a_in,     // left word
    input  spk_pkg::word_t b_in,     // right word
    input  spk_pkg::word_t k_in,     // round key
    input  logic           inv_in,   // high for the inverse round
    output spk_pkg::word_t a_out,
    output spk_pkg::word_t b_out
);
    import spk_pkg::*;

    word_t fwd_a;
    word_t fwd_b;
    word_t inv_a;
    word_t inv_b;
    word_t inv_diff;
    word_t xor_ab;

    // Forward: left = (ror8(left) + right) ^ k, right = rol3(right) ^ left
    always_comb begin
        fwd_a = ({a_in[ROT_A-1:0], a_in[WORD_W-1:ROT_A]} + b_in) ^ k_in;
        fwd_b = {b_in[WORD_W-ROT_B-1:0], b_in[WORD_W-1:WORD_W-ROT_B]} ^ fwd_a;
    end

    // Inverse: undo the xor and rotate on the right word, then the add
    always_comb begin
        xor_ab   = b_in ^ a_in;
        inv_b    = {xor_ab[ROT_B-1:0], xor_ab[WORD_W-1:ROT_B]};
        inv_diff = (a_in ^ k_in) - inv_b;
        inv_a    = {inv_diff[WORD_W-ROT_A-1:0], inv_diff[WORD_W-1:WORD_W-ROT_A]};
    end

    assign a_out = inv_in ? inv_a : fwd_a;
    assign b_out = inv_in ? inv_b : fwd_b;

endmodule

// ===== src/speck64_128_block_cipher.sv =====
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid / s_tready  s_tdata: in_left, in_right; s_tuser: opcode
// m_        out  m_tvalid / m_tready  m_tdata: out_left, out_right
// cfg_      in   cfg_wr_en            cfg_index, cfg_data (key words 0..3)
//
// An item runs its NUM_ROUNDS rounds through the single shared round unit and
// then returns to idle; one item at a time.
// After reset and after each key-word write the round keys are re-expanded on
// the same round unit, during which s_tready is low.
// A result waits in the output register; the final round stalls only if that
// register is still full when it is due. Reset is synchronous, active low.
`include "speck64_128_block_cipher_assert.svh"

module speck64_128_block_cipher #(
    parameter int NUM_ROUNDS = 27
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,    // in_left [31:0], in_right [63:32]
    input  logic [0:0]                    s_tuser,    // opcode [0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,    // out_left [31:0], out_right [63:32]
    input  logic                          cfg_wr_en,
    input  logic [spk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  spk_pkg::word_t                cfg_data
);
    import spk_pkg::*;

    localparam int CW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
    localparam logic [CW-1:0] LAST_RND = CW'(NUM_ROUNDS - 1);
    localparam logic [CW-1:0] LAST_EXP = CW'((NUM_ROUNDS > 1) ? NUM_ROUNDS - 2 : 0);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EXPAND,
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  cnt_reg;
    opcode_t        op_reg;
    word_t          a_reg;
    word_t          b_reg;
    word_t          w1_reg;
    word_t          w2_reg;
    word_t          out_left_reg;
    word_t          out_right_reg;
    logic           m_tvalid_reg;
    word_t          key_reg [KEY_WORDS];
    word_t          rk_mem  [NUM_ROUNDS];

    logic           cfg_hit;
    logic           out_free;
    logic [CW-1:0]  rk_idx;
    word_t          rk_word;
    word_t          rnd_k;
    logic           rnd_inv;
    word_t          rnd_a;
    word_t          rnd_b;

    assign cfg_hit  = cfg_wr_en && (cfg_index < CFG_IDX_W'(KEY_WORDS));
    assign out_free = !m_tvalid_reg || m_tready;

    // Key registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    key_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Round key store: first key on load, one new key per expansion step
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            rk_mem[0] <= key_reg[0];
        end else if (state_reg == ST_EXPAND) begin
            rk_mem[cnt_reg + CW'(1)] <= rnd_b;
        end
    end

    // Decrypt walks the keys backwards
    assign rk_idx  = (op_reg == OP_DEC) ? (LAST_RND - cnt_reg) : cnt_reg;
    assign rk_word = rk_mem[rk_idx];

    // Expansion keys each step with its own index
    assign rnd_k   = (state_reg == ST_EXPAND) ? {{(WORD_W - CW){1'b0}}, cnt_reg} : rk_word;
    assign rnd_inv = (state_reg == ST_RUN) && (op_reg == OP_DEC);

    spk_round u_round (
        .a_in   (a_reg),
        .b_in   (b_reg),
        .k_in   (rnd_k),
        .inv_in (rnd_inv),
        .a_out  (rnd_a),
        .b_out  (rnd_b)
    );

    // Sequencer: key expansion, then rounds on each item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    // window holds key words 1..3, the low word rides in b
                    a_reg     <= key_reg[1];
                    w1_reg    <= key_reg[2];
                    w2_reg    <= key_reg[3];
                    b_reg     <= key_reg[0];
                    cnt_reg   <= '0;
                    state_reg <= (NUM_ROUNDS > 1) ? ST_EXPAND : ST_IDLE;
                end
                ST_EXPAND: begin
                    // roll the window: updated word goes to the back
                    a_reg   <= w1_reg;
                    w1_reg  <= w2_reg;
                    w2_reg  <= rnd_a;
                    b_reg   <= rnd_b;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == LAST_EXP) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        a_reg     <= s_tdata[31:0];
                        b_reg     <= s_tdata[63:32];
                        op_reg    <= opcode_t'(s_tuser[0]);
                        cnt_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (cnt_reg != LAST_RND) begin
                        a_reg   <= rnd_a;
                        b_reg   <= rnd_b;
                        cnt_reg <= cnt_reg + CW'(1);
                    end else if (out_free) begin
                        // final round lands straight in the output register
                        out_left_reg  <= rnd_a;
                        out_right_reg <= rnd_b;
                        m_tvalid_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
            // a key change restarts the expansion
            if (cfg_hit) begin
                state_reg <= ST_LOAD;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};

    `SPK_ASSERT_NEXT(a_accept_starts_run, s_tvalid && s_tready && !cfg_hit, state_reg == ST_RUN)
    `SPK_ASSERT_NEXT(a_cfg_reloads, cfg_hit, state_reg == ST_LOAD)
    `SPK_ASSERT(a_cnt_range, cnt_reg <= LAST_RND)
    `SPK_ASSERT(a_result_from_run, $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_RUN))

endmodule
